### hdl/nmte_pkg.sv
// ----------------------------------------------------------------------------
// nmte_pkg
// Types and constants shared by the n-gram Markov text engine.
// ----------------------------------------------------------------------------
`default_nettype none

package nmte_pkg;

    localparam int SYM_BITS  = 7;
    localparam int NSYM      = 1 << SYM_BITS;
    localparam int ADDR_BITS = 2 * SYM_BITS;
    localparam int DEPTH     = 1 << ADDR_BITS;
    localparam int CNT_BITS  = 15;
    localparam int W_BITS    = 2;
    localparam int TOT_BITS  = 9;
    localparam int RND_BITS  = 16;

    localparam logic [CNT_BITS-1:0] CNT_MAX    = 15'd32767;
    localparam logic [SYM_BITS-1:0] SPACE_CODE = 7'd32;
    localparam logic [7:0]          RUN_MAX    = 8'd255;
    localparam logic [7:0]          STOP_RESET = 8'd7;

    typedef enum logic [1:0] {
        MODE_TRAIN    = 2'd0,
        MODE_QUANTIZE = 2'd1,
        MODE_GENERATE = 2'd2,
        MODE_RESTART  = 2'd3
    } t_mode;

    typedef enum logic [0:0] {
        KIND_SYMBOL   = 1'b0,
        KIND_QUANTIZE = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TRD,
        S_TWR,
        S_QMAX,
        S_QWT,
        S_GSUM,
        S_GDIV,
        S_GWALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol_in;
        logic [15:0] random_value;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [6:0] symbol_out;
        logic       stop;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic load;
        logic trd;
        logic twr;
        logic qmax;
        logic qwt;
        logic gsum;
        logic gdiv;
        logic gwalk;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic sweep_done;
        logic row_last;
        logic div_last;
        logic total_zero;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### hdl/nmte_ram.sv
// ----------------------------------------------------------------------------
// nmte_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nmte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/nmte_ctrl.sv
// ----------------------------------------------------------------------------
// nmte_ctrl
// Sequencer for clearing, training, quantizing and generating.
// ----------------------------------------------------------------------------
`default_nettype none

module nmte_ctrl
    import nmte_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic [1:0] i_mode,
    input  wire logic    i_sym_hi,
    input  wire t_status i_status,
    output logic         o_in_stall,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   w_accept;

    assign w_accept = (r_state == S_IDLE) && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_status.clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_mode'(i_mode))
                        MODE_TRAIN:    n_state = i_sym_hi ? S_IDLE : S_TRD;
                        MODE_QUANTIZE: n_state = S_QMAX;
                        MODE_GENERATE: n_state = S_GSUM;
                        MODE_RESTART:  n_state = S_IDLE;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_TRD:  n_state = S_TWR;
            S_TWR:  n_state = S_IDLE;
            S_QMAX: if (i_status.sweep_done) n_state = S_QWT;
            S_QWT: begin
                if (i_status.sweep_done) begin
                    n_state = i_status.row_last ? S_DONE : S_QMAX;
                end
            end
            S_GSUM: begin
                if (i_status.sweep_done) begin
                    n_state = i_status.total_zero ? S_DONE : S_GDIV;
                end
            end
            S_GDIV:  if (i_status.div_last) n_state = S_GWALK;
            S_GWALK: if (i_status.sweep_done) n_state = S_DONE;
            S_DONE:  if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = (r_state != S_IDLE);
        o_cmd.load  = w_accept;
        o_cmd.clear = (r_state == S_CLEAR);
        o_cmd.trd   = (r_state == S_TRD);
        o_cmd.twr   = (r_state == S_TWR);
        o_cmd.qmax  = (r_state == S_QMAX);
        o_cmd.qwt   = (r_state == S_QWT);
        o_cmd.gsum  = (r_state == S_GSUM);
        o_cmd.gdiv  = (r_state == S_GDIV);
        o_cmd.gwalk = (r_state == S_GWALK);
        o_cmd.fin   = (r_state == S_DONE);
    end

endmodule

`default_nettype wire

### hdl/nmte_dp.sv
// ----------------------------------------------------------------------------
// nmte_dp
// Datapath: count and weight tables, row sweeps, modulo unit, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nmte_dp
    import nmte_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_cmd,
    input  wire t_in_item  i_in_data,
    input  wire logic      i_cfg_valid,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic      i_out_stall,
    output t_status        o_status,
    output logic           o_out_valid,
    output t_out_item      o_out_data
);

    logic [ADDR_BITS-1:0] r_clr_addr;
    logic [SYM_BITS:0]    r_col;
    logic                 r_pv;
    logic [SYM_BITS-1:0]  r_pcol;
    logic [SYM_BITS-1:0]  r_row;
    logic [CNT_BITS-1:0]  r_max;
    logic [TOT_BITS-1:0]  r_total, r_rem, r_sum;
    logic [3:0]           r_div_cnt;
    logic [SYM_BITS-1:0]  r_sym;
    logic                 r_found;
    logic [SYM_BITS-1:0]  r_thist, r_ghist;
    logic [7:0]           r_run, r_limit;
    t_in_item             r_in;

    logic [CNT_BITS-1:0]  w_cnt;
    logic [W_BITS-1:0]    w_wt, w_q;
    logic                 w_sweep, w_done, w_out_free, w_fin;
    logic [ADDR_BITS-1:0] w_cnt_raddr, w_cnt_waddr, w_wt_waddr;
    logic                 w_cnt_we, w_wt_we;
    logic [CNT_BITS-1:0]  w_cnt_wdata;
    logic [W_BITS-1:0]    w_wt_wdata;
    logic [CNT_BITS+1:0]  w_c3, w_m1, w_m2, w_m3;
    logic [TOT_BITS:0]    w_rem_sh;
    logic [TOT_BITS-1:0]  w_sum_n;
    logic [7:0]           w_run_n;

    assign w_sweep    = i_cmd.qmax | i_cmd.qwt | i_cmd.gsum | i_cmd.gwalk;
    assign w_done     = r_col[SYM_BITS] && !r_pv;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_fin      = i_cmd.fin && w_out_free;

    assign o_status.clr_last   = &r_clr_addr;
    assign o_status.sweep_done = w_done;
    assign o_status.row_last   = &r_row;
    assign o_status.div_last   = (r_div_cnt == 4'd0);
    assign o_status.total_zero = (r_total == '0);
    assign o_status.out_free   = w_out_free;

    // weight = min(3, 3*count/max) by threshold compares
    assign w_c3 = {2'b00, w_cnt} + {1'b0, w_cnt, 1'b0};
    assign w_m1 = {2'b00, r_max};
    assign w_m2 = {1'b0, r_max, 1'b0};
    assign w_m3 = w_m1 + w_m2;
    always_comb begin
        if (r_max == '0)        w_q = 2'd0;
        else if (w_c3 >= w_m3)  w_q = 2'd3;
        else if (w_c3 >= w_m2)  w_q = 2'd2;
        else if (w_c3 >= w_m1)  w_q = 2'd1;
        else                    w_q = 2'd0;
    end

    assign w_cnt_raddr = i_cmd.trd ? {r_thist, r_in.symbol_in[SYM_BITS-1:0]}
                                   : {r_row, r_col[SYM_BITS-1:0]};
    assign w_cnt_we    = i_cmd.clear | i_cmd.twr;
    assign w_cnt_waddr = i_cmd.clear ? r_clr_addr
                                     : {r_thist, r_in.symbol_in[SYM_BITS-1:0]};
    assign w_cnt_wdata = i_cmd.clear ? '0
                       : ((w_cnt == CNT_MAX) ? w_cnt : w_cnt + 1'b1);
    assign w_wt_we     = i_cmd.clear | (i_cmd.qwt & r_pv);
    assign w_wt_waddr  = i_cmd.clear ? r_clr_addr : {r_row, r_pcol};
    assign w_wt_wdata  = i_cmd.clear ? '0 : w_q;

    nmte_ram #(.WIDTH(CNT_BITS), .DEPTH(DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_cnt)
    );

    nmte_ram #(.WIDTH(W_BITS), .DEPTH(DEPTH)) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (w_wt_we),
        .i_waddr (w_wt_waddr),
        .i_wdata (w_wt_wdata),
        .i_raddr ({r_ghist, r_col[SYM_BITS-1:0]}),
        .o_rdata (w_wt)
    );

    assign w_rem_sh = {r_rem, r_in.random_value[r_div_cnt]};
    assign w_sum_n  = r_sum + TOT_BITS'(w_wt);
    assign w_run_n  = (r_sym == SPACE_CODE)
                    ? ((r_run == RUN_MAX) ? r_run : r_run + 8'd1) : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_pv        <= 1'b0;
            r_thist     <= '0;
            r_ghist     <= '0;
            r_run       <= '0;
            r_limit     <= STOP_RESET;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_limit <= i_cfg_data;
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + 1'b1;

            r_pv <= w_sweep && !r_col[SYM_BITS];
            if (w_sweep) begin
                if (w_done)                r_col <= '0;
                else if (!r_col[SYM_BITS]) r_col <= r_col + 1'b1;
            end

            if (i_cmd.load && t_mode'(i_in_data.mode) == MODE_RESTART) begin
                r_ghist <= '0;
                r_run   <= '0;
            end
            if (i_cmd.twr) r_thist <= r_in.symbol_in[SYM_BITS-1:0];

            if (w_fin) begin
                o_out_valid <= 1'b1;
                if (t_mode'(r_in.mode) == MODE_QUANTIZE) begin
                    o_out_data <= '{kind: KIND_QUANTIZE, symbol_out: '0, stop: 1'b0};
                end else begin
                    o_out_data <= '{kind: KIND_SYMBOL, symbol_out: r_sym,
                                    stop: (w_run_n >= r_limit)};
                    r_ghist <= r_sym;
                    r_run   <= w_run_n;
                end
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pcol <= r_col[SYM_BITS-1:0];
        if (i_cmd.load) begin
            r_in    <= i_in_data;
            r_row   <= '0;
            r_max   <= '0;
            r_total <= '0;
            r_sum   <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.qmax && r_pv && w_cnt > r_max) r_max <= w_cnt;
        if (i_cmd.qwt && w_done) begin
            r_row <= r_row + 1'b1;
            r_max <= '0;
        end
        if (i_cmd.gsum) begin
            if (r_pv) r_total <= r_total + TOT_BITS'(w_wt);
            if (w_done) begin
                r_sym     <= r_in.random_value[SYM_BITS-1:0];
                r_rem     <= '0;
                r_div_cnt <= 4'd15;
            end
        end
        if (i_cmd.gdiv) begin
            r_div_cnt <= r_div_cnt - 1'b1;
            if (w_rem_sh >= {1'b0, r_total}) begin
                r_rem <= TOT_BITS'(w_rem_sh - {1'b0, r_total});
            end else begin
                r_rem <= TOT_BITS'(w_rem_sh);
            end
        end
        if (i_cmd.gwalk && r_pv) begin
            r_sum <= w_sum_n;
            if (!r_found && w_sum_n > r_rem) begin
                r_found <= 1'b1;
                r_sym   <= r_pcol;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/ngram_markov_text_engine_top.sv
// ----------------------------------------------------------------------------
// ngram_markov_text_engine_top
// Character bigram Markov engine: train, quantize, generate, restart.
// ----------------------------------------------------------------------------
// After reset the tables are cleared one entry per cycle; no transaction is
// accepted until the clear ends. Items are processed one at a time, paced by
// the single read port of each table: train reads then writes a count (not for
// a symbol of 128 or more), restart resets the context, generate sums the row
// weights, takes the random value modulo the sum and walks the row (sums only
// when the weights are all zero), and quantize makes two sweeps for each of
// 128 rows. A stalled result holds the next one, and with it the input.
`default_nettype none

module ngram_markov_text_engine_top
    import nmte_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    nmte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_data.mode),
        .i_sym_hi   (i_in_data.symbol_in[7]),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    nmte_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

### verif/ngram_markov_text_engine_top_tb.sv
// ----------------------------------------------------------------------------
// ngram_markov_text_engine_top_tb
// Self-checking testbench for the n-gram Markov text engine. Directed tests
// cover empty tables, training edge symbols, stop-limit settings and weight
// thresholds; random phases train text-like streams, quantize and generate
// under random idling and back-pressure. A scoreboard predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ngram_markov_text_engine_top_tb;
    import nmte_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE_CYCLES = 40;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = '0;

    ngram_markov_text_engine_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // model state
    logic [CNT_BITS-1:0] pair_counts [DEPTH];
    logic [W_BITS-1:0]   pair_weights [DEPTH];
    logic [SYM_BITS-1:0] train_ctx;
    logic [SYM_BITS-1:0] gen_ctx;
    logic [7:0]          space_run;
    logic [7:0]          stop_limit;

    t_out_item expected_results [$];

    int  mismatches = 0;
    int  unexpected = 0;
    int  n_train = 0, n_quant = 0, n_gen = 0, n_restart = 0, n_stops = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    int  hold_req = 0;
    int  stall_burst = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            i_out_stall <= 1'b1;
            hold_req--;
        end else if (stall_burst > 0) begin
            i_out_stall <= 1'b1;
            stall_burst--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_burst = $urandom_range(0, 5);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                unexpected++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d sym=%0d stop=%0d",
                             o_out_data.kind, o_out_data.symbol_out, o_out_data.stop);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.stop) n_stops++;
                if (o_out_data.kind !== want.kind || o_out_data.symbol_out !== want.symbol_out
                        || o_out_data.stop !== want.stop) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp kind=%0d sym=%0d stop=%0d, got kind=%0d sym=%0d stop=%0d",
                                 want.kind, want.symbol_out, want.stop,
                                 o_out_data.kind, o_out_data.symbol_out, o_out_data.stop);
                end
            end
        end
    end

    function automatic void rescale_rows();
        int mx, w;
        for (int row = 0; row < NSYM; row++) begin
            mx = 0;
            for (int s = 0; s < NSYM; s++)
                if (pair_counts[row * NSYM + s] > mx) mx = pair_counts[row * NSYM + s];
            for (int s = 0; s < NSYM; s++) begin
                w = 0;
                if (mx != 0) begin
                    w = (3 * int'(pair_counts[row * NSYM + s])) / mx;
                    if (w > 3) w = 3;
                end
                pair_weights[row * NSYM + s] = w[W_BITS-1:0];
            end
        end
    endfunction

    function automatic logic [SYM_BITS-1:0] draw_next(logic [15:0] rnd);
        int total, r, acc;
        total = 0;
        for (int s = 0; s < NSYM; s++) total += pair_weights[gen_ctx * NSYM + s];
        if (total == 0) return rnd[SYM_BITS-1:0];
        r = int'(rnd) % total;
        acc = 0;
        for (int s = 0; s < NSYM; s++) begin
            acc += pair_weights[gen_ctx * NSYM + s];
            if (acc > r) return s[SYM_BITS-1:0];
        end
        return '0;
    endfunction

    function automatic void predict_item(t_in_item it);
        t_out_item res;
        logic [SYM_BITS-1:0] s;
        int idx;
        case (t_mode'(it.mode))
            MODE_TRAIN: begin
                n_train++;
                if (it.symbol_in < NSYM) begin
                    idx = train_ctx * NSYM + it.symbol_in;
                    if (pair_counts[idx] != CNT_MAX) pair_counts[idx]++;
                    train_ctx = it.symbol_in[SYM_BITS-1:0];
                end
            end
            MODE_QUANTIZE: begin
                n_quant++;
                rescale_rows();
                res.kind = KIND_QUANTIZE;
                res.symbol_out = '0;
                res.stop = 1'b0;
                expected_results.push_back(res);
            end
            MODE_GENERATE: begin
                n_gen++;
                s = draw_next(it.random_value);
                gen_ctx = s;
                if (s == SPACE_CODE) begin
                    if (space_run != RUN_MAX) space_run++;
                end else begin
                    space_run = '0;
                end
                res.kind = KIND_SYMBOL;
                res.symbol_out = s;
                res.stop = (space_run >= stop_limit);
                expected_results.push_back(res);
            end
            default: begin
                n_restart++;
                gen_ctx = '0;
                space_run = '0;
            end
        endcase
    endfunction

    function automatic t_in_item make_item(t_mode m, logic [7:0] sym, logic [15:0] rnd);
        t_in_item it;
        it.mode = m;
        it.symbol_in = sym;
        it.random_value = rnd;
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_item(it);
    endtask

    task automatic send_mode(t_mode m, logic [7:0] sym, logic [15:0] rnd);
        send_item(make_item(m, sym, rnd));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_stop_limit(logic [7:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        stop_limit = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] text_symbol();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 8'($urandom_range(97, 122));
        if (pick < 75) return 8'd32;
        if (pick < 90) return 8'($urandom_range(0, 127));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_empty_tables();
        send_mode(MODE_QUANTIZE, 8'd0, 16'd0);
        send_mode(MODE_GENERATE, 8'd0, 16'hFFFF);
        send_mode(MODE_GENERATE, 8'd0, 16'h0000);
        send_mode(MODE_GENERATE, 8'd0, 16'h00A0);
        send_mode(MODE_RESTART, 8'hFF, 16'hFFFF);
        send_mode(MODE_GENERATE, 8'hFF, 16'h8020);
    endtask

    task automatic test_train_edges();
        send_mode(MODE_TRAIN, 8'd128, 16'hFFFF);
        send_mode(MODE_TRAIN, 8'd255, 16'd0);
        send_mode(MODE_TRAIN, 8'd0, 16'd0);
        send_mode(MODE_TRAIN, 8'd127, 16'd0);
        send_mode(MODE_TRAIN, 8'd0, 16'd0);
        send_mode(MODE_TRAIN, 8'd32, 16'd0);
        send_mode(MODE_QUANTIZE, 8'hAA, 16'h5555);
        send_mode(MODE_RESTART, 8'd0, 16'd0);
        send_mode(MODE_GENERATE, 8'd0, 16'd0);
        send_mode(MODE_GENERATE, 8'd0, 16'hFFFF);
    endtask

    // space row points only to space, so generated spaces run long
    task automatic test_stop_limits();
        logic [7:0] limits [4] = '{8'd0, 8'd1, 8'd3, 8'd255};
        repeat (20) send_mode(MODE_TRAIN, 8'd32, 16'($urandom));
        send_mode(MODE_QUANTIZE, 8'd0, 16'd0);
        foreach (limits[i]) begin
            write_stop_limit(limits[i]);
            send_mode(MODE_RESTART, 8'd0, 16'd0);
            repeat (limits[i] == 8'd255 ? 262 : 8) send_mode(MODE_GENERATE, 8'd0, 16'($urandom));
        end
        write_stop_limit(STOP_RESET);
    endtask

    // row 'x' gets counts 9, 6, 3, 2: weights 3, 2, 1, 0
    task automatic test_weight_ratios();
        int         reps [4] = '{9, 6, 3, 2};
        logic [7:0] syms [4] = '{8'd121, 8'd122, 8'd119, 8'd118};
        idle_on = 1'b0;
        send_mode(MODE_TRAIN, 8'd120, 16'd0);
        foreach (syms[i]) begin
            repeat (reps[i]) begin
                send_mode(MODE_TRAIN, syms[i], 16'($urandom));
                send_mode(MODE_TRAIN, 8'd120, 16'($urandom));
            end
        end
        send_mode(MODE_QUANTIZE, 8'd0, 16'd0);
        send_mode(MODE_RESTART, 8'd0, 16'd0);
        repeat (6) send_mode(MODE_GENERATE, 8'd0, 16'($urandom));
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        drain();
        hold_req = 700;
        repeat (6) send_mode(MODE_GENERATE, 8'd0, 16'($urandom));
        repeat (4) send_mode(MODE_TRAIN, text_symbol(), 16'($urandom));
        drain();
    endtask

    task automatic random_phase(int n_items);
        int pick;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_mode(MODE_TRAIN, text_symbol(), 16'($urandom));
            else if (pick < 95)
                send_mode(MODE_GENERATE, 8'($urandom), 16'($urandom));
            else
                send_mode(MODE_RESTART, 8'($urandom), 16'($urandom));
        end
        send_mode(MODE_QUANTIZE, 8'($urandom), 16'($urandom));
    endtask

    task automatic test_random();
        for (int p = 0; p < 4; p++) begin
            random_phase(150);
            write_stop_limit(8'($urandom_range(1, 4)));
        end
        write_stop_limit(8'd2);
        idle_on = 1'b0;
        random_phase(60);
    endtask

    initial begin
        for (int k = 0; k < DEPTH; k++) begin
            pair_counts[k] = '0;
            pair_weights[k] = '0;
        end
        train_ctx = '0;
        gen_ctx = '0;
        space_run = '0;
        stop_limit = STOP_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_tables();
        test_train_edges();
        test_stop_limits();
        test_weight_ratios();
        test_backpressure();
        test_random();

        drain();
        repeat (300) @(posedge i_clk);

        $display("covered %0d train, %0d quantize, %0d generate, %0d restart transactions",
                 n_train, n_quant, n_gen, n_restart);
        $display("%0d results flagged stop, %0d mismatches, %0d unexpected results",
                 n_stops, mismatches, unexpected);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### ngram_markov_text_engine_top.f
hdl/nmte_pkg.sv
hdl/nmte_ram.sv
hdl/nmte_ctrl.sv
hdl/nmte_dp.sv
hdl/ngram_markov_text_engine_top.sv
verif/ngram_markov_text_engine_top_tb.sv
